// File: hw/rtl/lpqp_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed query parser package
// Shared types and constants for the request deframer.
// ----------------------------------------------------------------------------
package lpqp_pkg;

  // Longest byte section that a length word may announce.
  localparam logic [31:0] MAX_FIELD_LEN = 32'd65535;

  // Number of bytes in a word section.
  localparam int unsigned WORD_BYTES = 4;

  // Message sections, in the order in which they arrive.
  typedef enum logic [3:0] {
    SEC_TYPE    = 4'd0,
    SEC_NAMELEN = 4'd1,
    SEC_NAME    = 4'd2,
    SEC_CMD     = 4'd3,
    SEC_KEYLEN  = 4'd4,
    SEC_KEY     = 4'd5,
    SEC_VTYPE   = 4'd6,
    SEC_VALLEN  = 4'd7,
    SEC_VALUE   = 4'd8
  } sec_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       with_value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [3:0]  section;
    logic [7:0]  byte_out;
    logic [15:0] byte_offset;
    logic        word_done;
    logic [31:0] word_value;
    logic        message_done;
    logic        length_error;
  } out_item_t;

endpackage

// File: hw/rtl/lpqp_parser.sv
// ----------------------------------------------------------------------------
// Length-prefixed query parser: section tracker
// Holds the parse state and tags each accepted byte with its section, offset
// and any completed word, in a single pass of shallow logic.
// ----------------------------------------------------------------------------
module lpqp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  lpqp_pkg::in_item_t in_item,
  output lpqp_pkg::out_item_t result
);

  lpqp_pkg::sec_t sec_r, sec_nxt;
  logic [15:0]    off_r, off_nxt;
  logic [31:0]    shift_r, shift_nxt;
  logic [15:0]    len_r, len_nxt;
  logic           form_r, form_nxt;

  lpqp_pkg::sec_t sec_cur;
  logic           form_cur;
  logic [16:0]    off_inc;
  logic           word_end;
  logic           mdone;
  logic           lerr;

  // Unreachable section codes fall back to the type word section.
  always_comb begin
    unique case (sec_r)
      lpqp_pkg::SEC_TYPE, lpqp_pkg::SEC_NAMELEN, lpqp_pkg::SEC_NAME,
      lpqp_pkg::SEC_CMD, lpqp_pkg::SEC_KEYLEN, lpqp_pkg::SEC_KEY,
      lpqp_pkg::SEC_VTYPE, lpqp_pkg::SEC_VALLEN,
      lpqp_pkg::SEC_VALUE: sec_cur = sec_r;
      default:             sec_cur = lpqp_pkg::SEC_TYPE;
    endcase
  end

  // The message form is sampled on the first byte of a message.
  assign form_cur = (sec_cur == lpqp_pkg::SEC_TYPE && off_r == 16'd0) ?
                    in_item.with_value : form_r;

  assign off_inc   = {1'b0, off_r} + 17'd1;
  assign shift_nxt = {shift_r[23:0], in_item.data_byte};
  assign word_end  = (off_r >= 16'(lpqp_pkg::WORD_BYTES - 1));

  // Next section, offset and length for the byte being taken.
  always_comb begin
    sec_nxt = sec_cur;
    off_nxt = off_inc[15:0];
    len_nxt = len_r;
    mdone   = 1'b0;
    lerr    = 1'b0;
    case (sec_cur)
      lpqp_pkg::SEC_NAME, lpqp_pkg::SEC_KEY, lpqp_pkg::SEC_VALUE: begin
        if (off_inc >= {1'b0, len_r}) begin
          off_nxt = 16'd0;
          if (sec_cur == lpqp_pkg::SEC_NAME) begin
            sec_nxt = lpqp_pkg::SEC_CMD;
          end else if (sec_cur == lpqp_pkg::SEC_KEY && form_cur) begin
            sec_nxt = lpqp_pkg::SEC_VTYPE;
          end else begin
            sec_nxt = lpqp_pkg::SEC_TYPE;
            mdone   = 1'b1;
          end
        end
      end
      default: begin
        if (word_end) begin
          off_nxt = 16'd0;
          if (sec_cur == lpqp_pkg::SEC_TYPE || sec_cur == lpqp_pkg::SEC_CMD ||
              sec_cur == lpqp_pkg::SEC_VTYPE) begin
            sec_nxt = lpqp_pkg::sec_t'(sec_cur + 4'd1);
          end else if (shift_nxt[31] || shift_nxt > lpqp_pkg::MAX_FIELD_LEN) begin
            // Negative or oversized length: restart the parser.
            lerr    = 1'b1;
            sec_nxt = lpqp_pkg::SEC_TYPE;
          end else if (shift_nxt == 32'd0) begin
            // Zero length skips the byte section that follows.
            if (sec_cur == lpqp_pkg::SEC_NAMELEN) begin
              sec_nxt = lpqp_pkg::SEC_CMD;
            end else if (sec_cur == lpqp_pkg::SEC_KEYLEN && form_cur) begin
              sec_nxt = lpqp_pkg::SEC_VTYPE;
            end else begin
              sec_nxt = lpqp_pkg::SEC_TYPE;
              mdone   = 1'b1;
            end
          end else begin
            len_nxt = shift_nxt[15:0];
            sec_nxt = lpqp_pkg::sec_t'(sec_cur + 4'd1);
          end
        end
      end
    endcase
  end

  assign form_nxt = form_cur;

  // Result of the byte being taken.
  always_comb begin
    result.section      = sec_cur;
    result.byte_out     = in_item.data_byte;
    result.byte_offset  = off_r;
    result.word_done    = 1'b0;
    result.word_value   = 32'd0;
    result.message_done = mdone;
    result.length_error = lerr;
    if (sec_cur != lpqp_pkg::SEC_NAME && sec_cur != lpqp_pkg::SEC_KEY &&
        sec_cur != lpqp_pkg::SEC_VALUE && word_end) begin
      result.word_done  = 1'b1;
      result.word_value = shift_nxt;
    end
  end

  // Parse state advances on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= lpqp_pkg::SEC_TYPE;
      off_r   <= 16'd0;
      shift_r <= 32'd0;
      len_r   <= 16'd0;
      form_r  <= 1'b0;
    end else if (accept) begin
      sec_r  <= sec_nxt;
      off_r  <= off_nxt;
      len_r  <= len_nxt;
      form_r <= form_nxt;
      if (sec_cur != lpqp_pkg::SEC_NAME && sec_cur != lpqp_pkg::SEC_KEY &&
          sec_cur != lpqp_pkg::SEC_VALUE) begin
        shift_r <= shift_nxt;
      end
    end
  end

endmodule

// File: hw/rtl/lpqp_out_buf.sv
// ----------------------------------------------------------------------------
// Length-prefixed query parser: result buffer
// Output register with a skid stage, so a new beat can be taken while a
// finished result waits on a stalled receiver.
// ----------------------------------------------------------------------------
module lpqp_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lpqp_pkg::out_item_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output lpqp_pkg::out_item_t out_data
);

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  lpqp_pkg::out_item_t out_data_r, out_data_nxt;
  lpqp_pkg::out_item_t skid_data_r, skid_data_nxt;
  logic                take;

  assign take = out_valid_r && !out_stall;

  // Move beats between the skid stage and the output register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hw/rtl/length_prefixed_query_parser_top.sv
// ----------------------------------------------------------------------------
// Length-prefixed query parser, top level
// Splits a request message, one byte per beat, into its type, name, command,
// key and optional value sections, and reports type, length and command words.
//
// Input channel: in_valid / in_stall / in_data carry one message byte and the
// form flag, which is sampled on the first byte of each message. Output
// channel: out_valid / out_stall / out_data carry one result per input byte,
// in order: section, byte, offset within the section, completed word,
// end-of-message and length error flags.
// Each accepted byte's result is registered in the output register, or in
// the skid stage on a stall. Throughput is one byte per cycle while in_stall
// is low, set by the single-pass section logic ahead of the output register.
// When the receiver stalls, the waiting result holds and one more byte is
// still taken into the skid stage; in_stall rises only while that stage is
// occupied. A bad length word flags length_error and the next byte starts a
// new message. Reset returns the parser to the type word section with no
// result pending.
// ----------------------------------------------------------------------------
module length_prefixed_query_parser_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpqp_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lpqp_pkg::out_item_t out_data
);

  logic                accept;
  logic                buf_full;
  lpqp_pkg::out_item_t result;

  // A beat is taken whenever the skid stage is free.
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  lpqp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_data),
    .result  (result)
  );

  lpqp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
